// File: design/keyed_byte_rotate_cipher_defines.svh
`ifndef KEYED_BYTE_ROTATE_CIPHER_DEFINES_SVH
`define KEYED_BYTE_ROTATE_CIPHER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define KBRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kbrc check failed");

// next-cycle implication, checked out of reset
`define KBRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kbrc check failed");

`endif

// File: design/kbrc_pkg.sv
`default_nettype none

package kbrc_pkg;

    localparam int KEY_BYTES = 16;
    localparam int POS_W     = $clog2(KEY_BYTES);
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int DIGIT_W   = 4;
    localparam int CIDX_W    = 3;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_KEY_LOW     = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_KEY_HIGH    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_KEY_DIGIT   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SHIFT_LIMIT = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_DIRECTION   = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0]  key_low;
        logic [WORD_W-1:0]  key_high;
        logic [DIGIT_W-1:0] key_digit;
        logic [BYTE_W-1:0]  shift_limit;
        logic               decipher;
    } cfg_t;

    // per-byte context handed from the counter stage to the transform
    typedef struct packed {
        logic [BYTE_W-1:0] key_byte;
        logic [BYTE_W-1:0] extra;
        logic              hit;
        logic              odd;
        logic [2:0]        rot;
        logic              decipher;
    } ctx_t;

endpackage

`default_nettype wire

// File: design/kbrc_cfg.sv
`default_nettype none

module kbrc_cfg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [kbrc_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [kbrc_pkg::WORD_W-1:0] cfg_wdata,
    output kbrc_pkg::cfg_t                   cfg
);

    kbrc_pkg::cfg_t cfg_reg;
    kbrc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                kbrc_pkg::CFG_KEY_LOW:     cfg_next.key_low     = cfg_wdata;
                kbrc_pkg::CFG_KEY_HIGH:    cfg_next.key_high    = cfg_wdata;
                kbrc_pkg::CFG_KEY_DIGIT:
                    cfg_next.key_digit = cfg_wdata[kbrc_pkg::DIGIT_W-1:0];
                kbrc_pkg::CFG_SHIFT_LIMIT:
                    cfg_next.shift_limit = cfg_wdata[kbrc_pkg::BYTE_W-1:0];
                kbrc_pkg::CFG_DIRECTION:   cfg_next.decipher    = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/kbrc_ctx.sv
`default_nettype none

module kbrc_ctx (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire kbrc_pkg::cfg_t cfg,
    input  wire logic          take,
    input  wire logic          restart,
    output kbrc_pkg::ctx_t     ctx
);

    logic [kbrc_pkg::POS_W-1:0]  position_reg, position_next;
    logic                        odd_reg, odd_next;
    logic [kbrc_pkg::BYTE_W-1:0] shift_reg, shift_next;

    logic [kbrc_pkg::POS_W-1:0]  pos_eff;
    logic                        odd_eff;
    logic [kbrc_pkg::BYTE_W-1:0] shift_eff;
    logic [kbrc_pkg::BYTE_W:0]   shift_inc;
    logic [kbrc_pkg::POS_W-1:0]  key_idx;
    logic [2*kbrc_pkg::WORD_W-1:0] key_all;

    // restart clears the counters ahead of this beat
    assign pos_eff   = restart ? '0 : position_reg;
    assign odd_eff   = restart ? 1'b0 : odd_reg;
    assign shift_eff = restart ? '0 : shift_reg;

    // odd phases use the mirrored key byte
    assign key_idx = odd_eff ? ~pos_eff : pos_eff;
    assign key_all = {cfg.key_high, cfg.key_low};

    always_comb begin
        ctx.key_byte = key_all[key_idx*kbrc_pkg::BYTE_W +: kbrc_pkg::BYTE_W];
        ctx.extra    = odd_eff ? {cfg.key_digit, 4'b0000} : {4'b0000, cfg.key_digit};
        ctx.hit      = (pos_eff == cfg.key_digit);
        ctx.odd      = odd_eff;
        ctx.rot      = shift_eff[2:0];
        ctx.decipher = cfg.decipher;
    end

    assign shift_inc = {1'b0, shift_eff} + 9'd1;

    always_comb begin
        position_next = position_reg;
        odd_next      = odd_reg;
        shift_next    = shift_reg;
        if (take) begin
            position_next = pos_eff + 1'b1;
            odd_next      = ~odd_eff;
            if (shift_inc > {1'b0, cfg.shift_limit}) begin
                shift_next = '0;
            end else begin
                shift_next = shift_inc[kbrc_pkg::BYTE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            odd_reg      <= 1'b0;
            shift_reg    <= '0;
        end else begin
            position_reg <= position_next;
            odd_reg      <= odd_next;
            shift_reg    <= shift_next;
        end
    end

endmodule

`default_nettype wire

// File: design/kbrc_xform.sv
`default_nettype none

module kbrc_xform (
    input  wire kbrc_pkg::ctx_t            ctx,
    input  wire logic [kbrc_pkg::BYTE_W-1:0] din,
    output logic      [kbrc_pkg::BYTE_W-1:0] dout
);

    function automatic logic [7:0] rot_l(input logic [7:0] b, input logic [2:0] s);
        logic [15:0] w;
        w = {b, b} << s;
        return w[15:8];
    endfunction

    function automatic logic [7:0] rot_r(input logic [7:0] b, input logic [2:0] s);
        logic [15:0] w;
        w = {b, b} >> s;
        return w[7:0];
    endfunction

    logic [7:0] mask;
    logic [7:0] enc_x, dec_r, dec_x;

    assign mask = ctx.key_byte ^ (ctx.hit ? ctx.extra : 8'h00);

    always_comb begin
        enc_x = (din ^ mask) ^ {8{ctx.odd}};
        dec_r = ctx.odd ? rot_r(din, ctx.rot) : rot_l(din, ctx.rot);
        dec_x = (dec_r ^ {8{ctx.odd}}) ^ mask;
        if (ctx.decipher) begin
            dout = dec_x;
        end else begin
            dout = ctx.odd ? rot_l(enc_x, ctx.rot) : rot_r(enc_x, ctx.rot);
        end
    end

endmodule

`default_nettype wire

// File: design/keyed_byte_rotate_cipher.sv
// path: an accepted input beat passes the input register, then the result register, to m_
// throughput: 1 byte per cycle, set by the input and result registers
// each holding one beat; s_ready drops only while a result is stalled
// reset: synchronous active-low aresetn clears counters, config and valids
`default_nettype none

module keyed_byte_rotate_cipher (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [kbrc_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [kbrc_pkg::WORD_W-1:0] cfg_wdata,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [kbrc_pkg::BYTE_W-1:0] s_data_byte,
    input  wire logic                        s_restart,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [kbrc_pkg::BYTE_W-1:0] m_result_byte
);

    kbrc_pkg::cfg_t cfg;
    kbrc_pkg::ctx_t ctx;
    kbrc_pkg::ctx_t ctx_reg;

    logic                        s1_valid_reg, s1_valid_next;
    logic [kbrc_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [kbrc_pkg::BYTE_W-1:0] out_byte_reg;
    logic [kbrc_pkg::BYTE_W-1:0] xf_byte;
    logic                        advance;
    logic                        take;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || advance;
    assign take    = s_valid && s_ready;

    kbrc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kbrc_ctx u_ctx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .take    (take),
        .restart (s_restart),
        .ctx     (ctx)
    );

    kbrc_xform u_xform (
        .ctx  (ctx_reg),
        .din  (s1_byte_reg),
        .dout (xf_byte)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (take) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ctx_reg     <= ctx;
            s1_byte_reg <= s_data_byte;
        end
        if (advance && s1_valid_reg) begin
            out_byte_reg <= xf_byte;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_byte = out_byte_reg;

endmodule

`default_nettype wire

// File: design/kbrc_checker.sv
`default_nettype none
`include "keyed_byte_rotate_cipher_defines.svh"

module kbrc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_result_byte
);

    // a stalled result beat holds
    `KBRC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_result_byte))

    // with the sink ready the input side never stalls
    `KBRC_ASSERT_NOW(a_no_stall, m_ready, s_ready)

    // input backpressure only comes from a waiting result
    `KBRC_ASSERT_NOW(a_bp_cause, !s_ready, m_valid && !m_ready)

    // a fresh result traces back to an accepted beat, through the input and result registers
    `KBRC_ASSERT_NOW(a_out_src, $rose(m_valid), $past(s_valid && s_ready, 2))

endmodule

bind keyed_byte_rotate_cipher kbrc_checker u_kbrc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_byte (m_result_byte)
);

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // first index past the register map, writes there must be ignored
    localparam logic [kbrc_pkg::CIDX_W-1:0] CFG_FIRST_UNUSED =
        kbrc_pkg::CFG_DIRECTION + 3'd1;
    localparam int SETTLE_CYCLES = 4;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [kbrc_pkg::CIDX_W-1:0]   cfg_index;
    logic [kbrc_pkg::WORD_W-1:0]   cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic [kbrc_pkg::BYTE_W-1:0]   s_data_byte;
    logic                          s_restart;
    logic                          m_valid;
    logic                          m_ready;
    logic [kbrc_pkg::BYTE_W-1:0]   m_result_byte;

    // predictor copy of the registers and the stream counters
    kbrc_pkg::cfg_t                cipher_cfg;
    logic [kbrc_pkg::POS_W-1:0]    byte_pos;
    logic                          on_odd;
    logic [kbrc_pkg::BYTE_W-1:0]   rot_count;

    logic [kbrc_pkg::BYTE_W-1:0]   expected_bytes[$];
    int                            err_count;
    int                            sent_count;
    int                            checked_count;
    int                            setting_count;
    int                            restart_count;
    int                            hold_request;
    bit                            sender_gaps;
    bit                            sink_stalls;

    keyed_byte_rotate_cipher DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_byte (m_result_byte)
    );

    always #2 aclk = ~aclk;

    function automatic logic [7:0] key_at(input logic [kbrc_pkg::POS_W-1:0] idx);
        if (idx[3]) begin
            return cipher_cfg.key_high[idx[2:0]*8 +: 8];
        end
        return cipher_cfg.key_low[idx[2:0]*8 +: 8];
    endfunction

    function automatic logic [7:0] rot_l(input logic [7:0] b, input logic [2:0] s);
        logic [15:0] w;
        w = {b, b} << s;
        return w[15:8];
    endfunction

    function automatic logic [7:0] rot_r(input logic [7:0] b, input logic [2:0] s);
        logic [15:0] w;
        w = {b, b} >> s;
        return w[7:0];
    endfunction

    // transforms one byte and advances the stream counters
    function automatic logic [7:0] cipher_byte(input logic [7:0] din, input logic rst);
        logic [7:0] b;
        logic [7:0] kb;
        logic [7:0] extra;
        logic       hit;
        logic [2:0] rot;
        logic [8:0] nxt;
        if (rst) begin
            byte_pos  = '0;
            on_odd    = 1'b0;
            rot_count = '0;
        end
        kb    = on_odd ? key_at(4'd15 - byte_pos) : key_at(byte_pos);
        hit   = (byte_pos == cipher_cfg.key_digit);
        extra = on_odd ? {cipher_cfg.key_digit, 4'h0} : {4'h0, cipher_cfg.key_digit};
        rot   = rot_count[2:0];
        b     = din;
        if (!cipher_cfg.decipher) begin
            b = b ^ kb;
            if (hit) b = b ^ extra;
            if (on_odd) b = ~b;
            b = on_odd ? rot_l(b, rot) : rot_r(b, rot);
        end else begin
            b = on_odd ? rot_r(b, rot) : rot_l(b, rot);
            if (on_odd) b = ~b;
            if (hit) b = b ^ extra;
            b = b ^ kb;
        end
        on_odd   = ~on_odd;
        byte_pos = byte_pos + 1'b1;
        nxt      = rot_count + 9'd1;
        if (nxt > cipher_cfg.shift_limit) nxt = '0;
        rot_count = nxt[7:0];
        return b;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic rst);
        int unsigned gap;
        logic [7:0]  want_byte;
        gap = (sender_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= data;
        s_restart   <= rst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want_byte      = cipher_byte(data, rst);
        expected_bytes = {expected_bytes, want_byte};
        sent_count++;
        if (rst) restart_count++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [kbrc_pkg::CIDX_W-1:0] idx,
                             input logic [kbrc_pkg::WORD_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            kbrc_pkg::CFG_KEY_LOW:     cipher_cfg.key_low     = val;
            kbrc_pkg::CFG_KEY_HIGH:    cipher_cfg.key_high    = val;
            kbrc_pkg::CFG_KEY_DIGIT:
                cipher_cfg.key_digit   = val[kbrc_pkg::DIGIT_W-1:0];
            kbrc_pkg::CFG_SHIFT_LIMIT:
                cipher_cfg.shift_limit = val[kbrc_pkg::BYTE_W-1:0];
            kbrc_pkg::CFG_DIRECTION:   cipher_cfg.decipher    = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [kbrc_pkg::WORD_W-1:0] lo,
                                input logic [kbrc_pkg::WORD_W-1:0] hi,
                                input logic [3:0] digit, input logic [7:0] limit,
                                input logic dir);
        wait_idle();
        write_reg(kbrc_pkg::CFG_KEY_LOW, lo);
        write_reg(kbrc_pkg::CFG_KEY_HIGH, hi);
        write_reg(kbrc_pkg::CFG_KEY_DIGIT, {60'd0, digit});
        write_reg(kbrc_pkg::CFG_SHIFT_LIMIT, {56'd0, limit});
        write_reg(kbrc_pkg::CFG_DIRECTION, {63'd0, dir});
        setting_count++;
    endtask

    // all registers at reset: zero key, no rotation, encipher
    task automatic test_reset_state();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_unused_index();
        logic [kbrc_pkg::CIDX_W-1:0] idx;
        wait_idle();
        for (idx = CFG_FIRST_UNUSED; idx != '0; idx++) begin
            write_reg(idx, '1);
        end
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h81, 1'b0);
    endtask

    task automatic test_directed();
        // digit above nine, full-width key, rotation walks 0..7
        apply_config(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 4'd15, 8'd7, 1'b0);
        send_byte(8'h00, 1'b1);
        for (int i = 0; i < 15; i++) begin
            send_byte((i % 2) ? 8'hFF : 8'h80 >> (i % 8), 1'b0);
        end
        send_byte(8'h01, 1'b0);
        apply_config('1, '0, 4'd10, 8'd255, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
    endtask

    // sink holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        wait_idle();
        sender_gaps  = 1'b0;
        hold_request = 300;
        for (int i = 0; i < 30; i++) begin
            send_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic test_random_streams();
        logic [kbrc_pkg::WORD_W-1:0] lo;
        logic [kbrc_pkg::WORD_W-1:0] hi;
        logic [3:0]                  digit;
        logic [7:0]                  limit;
        int                          n;
        int unsigned                 sel;
        for (int ph = 0; ph < 6; ph++) begin
            sel   = $urandom_range(0, 3);
            lo    = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
            sel   = $urandom_range(0, 3);
            hi    = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
            sel   = $urandom_range(0, 3);
            digit = (sel == 0) ? 4'd0 : (sel == 1) ? 4'd15 : 4'($urandom_range(0, 15));
            sel   = $urandom_range(0, 3);
            limit = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(0, 255));
            // first stream long enough for the shift counter to wrap from its top
            if (ph == 0) limit = 8'd255;
            n = (ph == 0) ? 300 : 60;
            // a stream carries on across settings, so a lowered limit bites mid-stream
            apply_config(lo, hi, digit, limit, 1'($urandom));
            sender_gaps = (ph % 3) != 1;
            sink_stalls = (ph % 3) != 2;
            for (int i = 0; i < n; i++) begin
                send_byte(8'($urandom), (ph != 0) && ($urandom_range(0, 29) == 0));
            end
        end
    endtask

    initial begin : result_sink
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request != 0) begin
                m_ready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        logic [kbrc_pkg::BYTE_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                err_count++;
                $display("%0t: result beat with nothing expected, got %02h",
                         $time, m_result_byte);
            end else begin
                want = expected_bytes.pop_front();
                checked_count++;
                if (m_result_byte !== want) begin
                    err_count++;
                    $display("%0t: result_byte mismatch, expected %02h, actual %02h",
                             $time, want, m_result_byte);
                end
            end
        end
    end

    initial begin : stimulus
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= '0;
        cfg_wdata   <= '0;
        s_valid     <= 1'b0;
        s_data_byte <= '0;
        s_restart   <= 1'b0;
        cipher_cfg    = '0;
        byte_pos      = '0;
        on_odd        = 1'b0;
        rot_count     = '0;
        err_count     = 0;
        sent_count    = 0;
        checked_count = 0;
        setting_count = 0;
        restart_count = 0;
        hold_request  = 0;
        sender_gaps   = 1'b1;
        sink_stalls   = 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_unused_index();
        test_directed();
        test_backpressure();
        test_random_streams();

        wait_idle();
        repeat (10) @(posedge aclk);
        if (expected_bytes.size() != 0) begin
            err_count++;
            $display("%0t: %0d results never arrived", $time, expected_bytes.size());
        end
        $display("sent %0d bytes (%0d with restart), checked %0d results",
                 sent_count, restart_count, checked_count);
        $display("covered %0d register settings, both directions, a long sink hold-off",
                 setting_count);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("%0t: timed out", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: keyed_byte_rotate_cipher.f
+incdir+design
design/kbrc_pkg.sv
design/kbrc_cfg.sv
design/kbrc_ctx.sv
design/kbrc_xform.sv
design/keyed_byte_rotate_cipher.sv
design/kbrc_checker.sv
test/tb_top.sv
